/* rtl/lbp_pkg.sv */
// Shared types, constants and helper functions for the rotation-invariant LBP block.
// Used by every module under rtl; depends on nothing else.
package lbp_pkg;

  // Default frame limits, used as parameter defaults on the top level.
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 11;
  localparam logic [CfgIdxW-1:0]  CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0]  CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CfgDataW-1:0] WIDTH_RESET  = 11'd128;
  localparam logic [CfgDataW-1:0] HEIGHT_RESET = 11'd168;
  localparam logic [CfgDataW-1:0] MIN_SIZE     = 11'd3;

  // Output queue depth.
  localparam int unsigned FifoDepth = 2;

  // One line store entry: the two earlier rows at the same column.
  typedef struct packed {
    logic [7:0] upper;
    logic [7:0] middle;
  } lbp_line_t;

  // One result word.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } lbp_result_t;

  // Least of the eight 8-bit rotations of a code.
  function automatic logic [7:0] least_rotation(logic [7:0] code);
    logic [7:0] best;
    logic [7:0] cur;
    best = code;
    cur  = code;
    for (int k = 0; k < 7; k++) begin
      cur = {cur[6:0], cur[7]};
      if (cur < best) begin
        best = cur;
      end
    end
    return best;
  endfunction

endpackage

/* rtl/lbp_rotation_invariant_3x3.sv */
// Rotation-invariant 8-neighbor local binary pattern over a 3x3 window.
// Top level; uses lbp_pkg, lbp_line_mem, lbp_window and lbp_out_fifo.
//
// Grey pixels enter in raster order, one word per clock when the output side keeps up.
// A single line store, one 16-bit entry per column holding the two previous rows, is
// read when a pixel is taken and written back in the next cycle, so one pixel per cycle
// is sustained while the output side keeps up; a write to the entry read in the same
// cycle is forwarded. The result word for an interior center is formed from the
// stage-one registers and passes through a two-word output queue, and input stalls
// when that queue could not hold a result for every pixel in flight, border pixels
// included. Border pixels give no word. Frame size comes from two registers (0: width,
// 1: height), clamped into [3, MAX_WIDTH] and [3, MAX_HEIGHT]; they may be written
// only while the block is idle. The line store has no reset and needs no clearing
// pass: stale entries reach only the first two rows of a frame of constant width,
// which give no word.
module lbp_rotation_invariant_3x3 #(
  parameter int unsigned MAX_WIDTH  = lbp_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = lbp_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    pixel_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    lbp_code_o,
  output logic                          last_in_frame_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lbp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lbp_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [CfgDataW-1:0] width_q, height_q;
  logic [ColW-1:0]     col_q, col_d, col_cur, col_last;
  logic [RowW-1:0]     row_q, row_d, row_cur, row_last;
  logic                in_acc;
  logic                pop;
  logic [CntW-1:0]     fifo_count;
  logic [CntW:0]       credit;

  logic                s1_valid_q;
  logic [ColW-1:0]     s1_addr_q;
  logic [7:0]          s1_pixel_q;
  lbp_result_t         s1_info_q;
  logic                s1_emit_q;
  logic                emit_cur;
  logic                last_cur;

  lbp_line_t           rd_line;
  lbp_line_t           wr_line;
  logic [7:0]          code;
  lbp_result_t         push_data;
  lbp_result_t         out_data;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Last column and row index after clamping the frame size.
  always_comb begin
    if (width_q < MIN_SIZE) begin
      col_last = ColW'(2);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      col_last = ColW'(MAX_WIDTH - 1);
    end else begin
      col_last = ColW'(width_q - CfgDataW'(1));
    end
    if (height_q < MIN_SIZE) begin
      row_last = RowW'(2);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      row_last = RowW'(MAX_HEIGHT - 1);
    end else begin
      row_last = RowW'(height_q - CfgDataW'(1));
    end
  end

  // Input acceptance: room is kept for everything in flight plus the new word.
  assign pop        = out_valid_o && out_ready_i;
  assign credit     = (CntW + 1)'(fifo_count) + (CntW + 1)'(s1_valid_q) - (CntW + 1)'(pop);
  assign in_ready_o = credit < (CntW + 1)'(FifoDepth);
  assign in_acc     = in_valid_i && in_ready_o;

  // Position of the current pixel and of the next one.
  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    row_cur  = frame_start_i ? '0 : row_q;
    emit_cur = (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
    last_cur = (row_cur >= row_last) && (col_cur >= col_last);
    if (col_cur >= col_last) begin
      col_d = '0;
      row_d = (row_cur >= row_last) ? '0 : row_cur + RowW'(1);
    end else begin
      col_d = col_cur + ColW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage one holds the pixel while the line store read returns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s1_emit_q  <= in_acc && emit_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q      <= col_cur;
      s1_pixel_q     <= pixel_i;
      s1_info_q.code <= 8'd0;
      s1_info_q.last <= last_cur;
    end
  end

  // Read at the current column, write the rows shifted up in the cycle after.
  assign wr_line.upper  = rd_line.middle;
  assign wr_line.middle = s1_pixel_q;

  lbp_line_mem #(
    .Depth(MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_cur),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_line),
    .rd_data_o (rd_line)
  );

  lbp_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_valid_q),
    .upper_i  (rd_line.upper),
    .middle_i (rd_line.middle),
    .pixel_i  (s1_pixel_q),
    .code_o   (code)
  );

  // Interior centers go to the output queue.
  assign push_data.code = code | s1_info_q.code;
  assign push_data.last = s1_info_q.last;

  lbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_emit_q),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data),
    .count_o     (fifo_count)
  );

  assign lbp_code_o      = out_data.code;
  assign last_in_frame_o = out_data.last;

  // Counters stay in range, and a full queue with a pixel in flight stops the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(MAX_WIDTH))
    else $error("column count past the line store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < 32'(MAX_HEIGHT))
    else $error("row count past the frame limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_count == CntW'(FifoDepth)) && s1_valid_q |-> !in_ready_o)
    else $error("input taken with no room for its result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_emit_q |-> s1_valid_q)
    else $error("result pushed without a pixel in flight");

endmodule

/* rtl/lbp_line_mem.sv */
// Line store for the two previous rows, one entry per column, with write forwarding.
// Depends on lbp_pkg for the entry type.
module lbp_line_mem #(
  parameter int unsigned Depth = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [$clog2(Depth)-1:0]  rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(Depth)-1:0]  wr_addr_i,
  input  lbp_pkg::lbp_line_t        wr_data_i,
  output lbp_pkg::lbp_line_t        rd_data_o
);
  import lbp_pkg::*;

  lbp_line_t mem [Depth];
  lbp_line_t rdata_q;
  lbp_line_t fwd_data_q;
  logic      fwd_hit_q;
  logic      fwd_hit_d;

  // Synchronous memory: read-before-write, with the read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // A write to the entry being read in the same cycle is forwarded.
  always_comb begin
    fwd_hit_d = fwd_hit_q;
    if (rd_en_i) begin
      fwd_hit_d = wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rdata_q;

endmodule

/* rtl/lbp_window.sv */
// 3x3 pixel window and the comparison code with its least rotation.
// Depends on lbp_pkg for least_rotation.
module lbp_window (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] upper_i,
  input  logic [7:0] middle_i,
  input  logic [7:0] pixel_i,
  output logic [7:0] code_o
);
  import lbp_pkg::*;

  logic [7:0] win_q [9];
  logic [7:0] win_d [9];
  logic [7:0] raw_code;
  logic [7:0] ctr;

  // Shift the three rows left and load the new column on the right.
  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = upper_i;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = middle_i;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = pixel_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= 8'd0;
      end
    end else if (shift_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // Neighbors clockwise from top-left, each strictly above the center.
  always_comb begin
    ctr         = win_d[4];
    raw_code[0] = win_d[0] > ctr;
    raw_code[1] = win_d[1] > ctr;
    raw_code[2] = win_d[2] > ctr;
    raw_code[3] = win_d[5] > ctr;
    raw_code[4] = win_d[8] > ctr;
    raw_code[5] = win_d[7] > ctr;
    raw_code[6] = win_d[6] > ctr;
    raw_code[7] = win_d[3] > ctr;
  end

  assign code_o = least_rotation(raw_code);

endmodule

/* rtl/lbp_out_fifo.sv */
// Small output queue that holds finished result words until they are taken.
// Depends on lbp_pkg for the result type and depth.
module lbp_out_fifo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  lbp_pkg::lbp_result_t                   push_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output lbp_pkg::lbp_result_t                   out_data_o,
  output logic [$clog2(lbp_pkg::FifoDepth+1)-1:0] count_o
);
  import lbp_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  lbp_result_t          mem_q [FifoDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never passes the depth, and a full queue takes no word it cannot hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("output queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(FifoDepth)) && push_i |-> pop)
    else $error("push into a full output queue");

  // A word is only handed out from a queue that holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (count_q != '0))
    else $error("pop from an empty output queue");

endmodule

/* sim/tb_lbp_rotation_invariant_3x3.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lbp_rotation_invariant_3x3: streams pixel frames at several sizes,
// predicts the rotation-invariant LBP code of every interior pixel and checks each result word.
// Depends on lbp_pkg and the RTL top level.
module tb_lbp_rotation_invariant_3x3;
  import lbp_pkg::*;

  localparam int unsigned LineLen      = DefMaxWidth;
  localparam int unsigned MaxRows      = DefMaxHeight;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit  = 10;

  // One pixel word as the driver presents it.
  typedef struct packed {
    logic [7:0] px;
    logic       sof;
  } pix_word_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [7:0]          pixel_i         = '0;
  logic                frame_start_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [7:0]          lbp_code_o;
  logic                last_in_frame_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  // Predictor state: size registers, line stores, window and raster position.
  logic [CfgDataW-1:0] width_reg  = WIDTH_RESET;
  logic [CfgDataW-1:0] height_reg = HEIGHT_RESET;
  bit [7:0]            upper_ln [LineLen];
  bit [7:0]            middle_ln [LineLen];
  bit [7:0]            win [9];
  int unsigned         col_cnt;
  int unsigned         row_cnt;

  lbp_result_t         code_q [$];
  pix_word_t           pixel_q [$];
  int unsigned         fail_count;
  int unsigned         gen_col;
  int unsigned         gen_row;
  bit                  steady;
  bit                  squeeze;
  logic                hold_off = 1'b0;

  lbp_rotation_invariant_3x3 i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pixel_i         (pixel_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lbp_code_o      (lbp_code_o),
    .last_in_frame_o (last_in_frame_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Effective frame dimension after saturation.
  function automatic int unsigned fit_size(logic [CfgDataW-1:0] v, int unsigned top);
    if (v < MIN_SIZE) begin
      return MIN_SIZE;
    end
    if (v > top) begin
      return top;
    end
    return v;
  endfunction

  // Advance the pixel model by one accepted word and queue the code it yields, if any.
  function automatic void lbp_predict(pix_word_t wd);
    int unsigned w, h, c, r;
    bit [7:0]    up, mid, ctr, code, best, rot;
    bit [15:0]   twice;
    lbp_result_t res;
    w = fit_size(width_reg, LineLen);
    h = fit_size(height_reg, MaxRows);
    if (wd.sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    up  = upper_ln[c];
    mid = middle_ln[c];
    upper_ln[c]  = mid;
    middle_ln[c] = wd.px;
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = wd.px;
    if (r >= 2 && c >= 2) begin
      ctr  = win[4];
      // Clockwise from top-left in bit 0 to the left neighbor in bit 7.
      code = {win[3] > ctr, win[6] > ctr, win[7] > ctr, win[8] > ctr,
              win[5] > ctr, win[2] > ctr, win[1] > ctr, win[0] > ctr};
      // Take the smallest of all eight rotate-lefts.
      twice = {code, code};
      best  = code;
      for (int k = 1; k < 8; k++) begin
        rot = twice[15-k -: 8];
        if (rot < best) begin
          best = rot;
        end
      end
      res.code = best;
      res.last = (r >= h - 1) && (c >= w - 1);
      code_q = {code_q, res};
    end
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // Wait until every word has gone through, then let the pipeline settle.
  task automatic drain();
    do @(negedge clk_i); while (pixel_q.size() != 0 || in_valid_i || code_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
  endtask

  // Reconfigure the frame size once the block has gone idle.
  task automatic set_size(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h);
    drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // A 3x3 frame whose neighbors selected by mask take hi and the others lo.
  task automatic push_window(bit [7:0] ctr, bit [7:0] mask, bit [7:0] hi, bit [7:0] lo,
                             bit sof);
    pix_word_t wd;
    int        b;
    @(negedge clk_i);
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: b = 0;
        1: b = 1;
        2: b = 2;
        3: b = 7;
        5: b = 3;
        6: b = 6;
        7: b = 5;
        8: b = 4;
        default: b = -1;
      endcase
      wd.sof = sof && (p == 0);
      wd.px  = (b < 0) ? ctr : (mask[b] ? hi : lo);
      pixel_q = {pixel_q, wd};
    end
  endtask

  // Random raster stream: start flags mostly on true frame starts, with optional
  // stray starts mid-frame; pixels mix full-range, near-flat and saturated values.
  task automatic push_stream(int unsigned n, bit lead_sof, bit noisy, bit calm);
    int unsigned w, h;
    pix_word_t   wd;
    bit [7:0]    base;
    w = fit_size(width_reg, LineLen);
    h = fit_size(height_reg, MaxRows);
    base = 8'($urandom);
    @(negedge clk_i);
    steady = calm;
    for (int unsigned i = 0; i < n; i++) begin
      if (gen_col == 0 && gen_row == 0) begin
        base = 8'($urandom);
      end
      wd.sof = (i == 0 && lead_sof)
            || (gen_col == 0 && gen_row == 0 && $urandom_range(0, 3) != 0)
            || (noisy && $urandom_range(0, 79) == 0);
      case ($urandom_range(0, 3))
        0, 1: wd.px = 8'($urandom);
        2: wd.px = 8'(base + $urandom_range(0, 2));
        default: wd.px = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      endcase
      if (wd.sof) begin
        gen_col = 0;
        gen_row = 0;
      end
      if (gen_col >= w - 1) begin
        gen_col = 0;
        gen_row = (gen_row >= h - 1) ? 0 : gen_row + 1;
      end else begin
        gen_col++;
      end
      pixel_q = {pixel_q, wd};
    end
  endtask

  // Pixel driver: presents one word at a time, with a random gap after each unless steady.
  always @(posedge clk_i) begin : pixel_drive_p
    bit          busy;
    int unsigned tx_gap;
    pix_word_t   wd;
    if (rst_ni) begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        wd.px  = pixel_i;
        wd.sof = frame_start_i;
        lbp_predict(wd);
        busy = 1'b0;
      end
      if (!busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pixel_q.size() != 0) begin
          wd = pixel_q.pop_front();
          pixel_i       <= wd.px;
          frame_start_i <= wd.sof;
          busy   = 1'b1;
          tx_gap = steady ? 0 : $urandom_range(0, 6);
        end
      end
      in_valid_i <= busy;
    end
  end

  // Result monitor: compares each accepted word with the oldest predicted code.
  always @(posedge clk_i) begin : result_check_p
    lbp_result_t want;
    int unsigned rx_gap;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (code_q.size() == 0) begin
          if (fail_count < ReportLimit) begin
            $display("unexpected result word: code %02h last %0b",
                     lbp_code_o, last_in_frame_o);
          end
          fail_count++;
        end else begin
          want = code_q.pop_front();
          if (lbp_code_o !== want.code || last_in_frame_o !== want.last) begin
            if (fail_count < ReportLimit) begin
              $display("mismatch: expected code %02h last %0b, got code %02h last %0b",
                       want.code, want.last, lbp_code_o, last_in_frame_o);
            end
            fail_count++;
          end
        end
        rx_gap = steady ? 0 : $urandom_range(0, 6);
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      out_ready_i <= (rx_gap == 0) && !hold_off;
    end
  end

  // Long receiver stall in the middle of a busy stream so the input side backs up.
  initial begin : backpressure_p
    wait (squeeze);
    repeat (40) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog_p
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus_p
    int unsigned nw, nh, cur_w;
    bit          lead;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the smallest size.
    set_size(11'd3, 11'd3);
    // Every neighbor brighter than a black center.
    push_window(8'h00, 8'hff, 8'hff, 8'h00, 1'b1);
    // White center on black; this frame follows without a start flag.
    push_window(8'hff, 8'h00, 8'h00, 8'h00, 1'b0);
    // Only the left and top-left neighbors brighter, the rest equal to the center.
    push_window(8'd100, 8'h81, 8'd101, 8'd100, 1'b1);

    // Registers below the minimum size, no idling.
    set_size(11'd0, 11'd2);
    push_stream(60, 1'b1, 1'b1, 1'b1);
    // Medium frames with the long receiver stall; ends partway into a frame.
    set_size(11'd16, 11'd12);
    squeeze = 1'b1;
    push_stream(250, 1'b1, 1'b1, 1'b0);
    // Shrink both sizes mid-frame: column and row wrap at the new limits.
    set_size(11'd9, 11'd4);
    push_stream(100, 1'b0, 1'b1, 1'b0);
    // Widest frame, width register saturated; only the start of the first row.
    set_size(11'h7ff, 11'd3);
    push_stream(150, 1'b1, 1'b0, 1'b0);
    // Tallest frames: exact maximum height, then a saturated height mid-frame.
    set_size(11'd3, 11'd1024);
    push_stream(120, 1'b1, 1'b1, 1'b0);
    set_size(11'd3, 11'h7ff);
    push_stream(60, 1'b0, 1'b1, 1'b1);

    // Random small sizes; a wider frame always starts fresh.
    repeat (5) begin
      cur_w = fit_size(width_reg, LineLen);
      nw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      nh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      set_size(nw[CfgDataW-1:0], nh[CfgDataW-1:0]);
      lead = (fit_size(nw[CfgDataW-1:0], LineLen) > cur_w) || ($urandom_range(0, 1) != 0);
      push_stream($urandom_range(20, 40), lead, 1'b1, $urandom_range(0, 3) == 0);
    end

    drain();
    if (fail_count == 0 && code_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lbp_pkg.sv
rtl/lbp_line_mem.sv
rtl/lbp_window.sv
rtl/lbp_out_fifo.sv
rtl/lbp_rotation_invariant_3x3.sv
sim/tb_lbp_rotation_invariant_3x3.sv
